### rtl/dfpr_pkg.sv
package dfpr_pkg;

  // Default geometry
  localparam int unsigned TEXT_DEPTH_DEF = 32;
  localparam int unsigned BIN_LEN_DEF    = 3;

  // Framing bytes
  localparam logic [7:0] BIN_HEAD = 8'hFF;
  localparam logic [7:0] BIN_TAIL = 8'hFE;
  localparam logic [7:0] TXT_HEAD = 8'h40;  // '@'
  localparam logic [7:0] TXT_STOP = 8'h2A;  // '*'
  localparam logic [7:0] TXT_TAIL = 8'h26;  // '&'

  // Frame kinds
  localparam logic KIND_BIN = 1'b0;
  localparam logic KIND_TXT = 1'b1;

  // Output field widths
  localparam int unsigned BYTE_W  = 8;
  localparam int unsigned INDEX_W = 5;
  localparam int unsigned LEN_W   = 6;
  localparam int unsigned TDATA_W = 24;

  // Controller to datapath commands
  typedef struct packed {
    logic start_frame;  // clear write position and overflow flag
    logic store_byte;   // write the incoming word into the store
    logic set_ovf;      // note a dropped text byte
    logic start_emit;   // begin sending the stored payload
    logic kind;         // frame kind for start_emit
  } cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic is_bin_head;
    logic is_bin_tail;
    logic is_txt_head;
    logic is_txt_stop;
    logic is_txt_tail;
    logic bin_last;     // this binary byte completes the payload
    logic txt_full;     // text store holds its full depth
    logic emit_done;    // last output word taken this cycle
  } status_t;

endpackage

### rtl/dfpr_ctrl.sv
module dfpr_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  dfpr_pkg::status_t status_i,
  output dfpr_pkg::cmd_t    cmd_o
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_BIN_DATA,
    ST_BIN_WAIT,
    ST_TXT_DATA,
    ST_TXT_WAIT,
    ST_EMIT
  } state_e;

  state_e state_q, state_d;
  logic   acc;

  // Take input words whenever no frame is being sent
  assign in_ready_o = (state_q != ST_EMIT);
  assign acc        = in_valid_i && in_ready_o;

  // Decode next state and commands
  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      ST_IDLE: begin
        if (acc && status_i.is_bin_head) begin
          cmd_o.start_frame = 1'b1;
          state_d = ST_BIN_DATA;
        end else if (acc && status_i.is_txt_head) begin
          cmd_o.start_frame = 1'b1;
          state_d = ST_TXT_DATA;
        end
      end
      ST_BIN_DATA: begin
        if (acc) begin
          cmd_o.store_byte = 1'b1;
          if (status_i.bin_last) begin
            state_d = ST_BIN_WAIT;
          end
        end
      end
      ST_BIN_WAIT: begin
        if (acc && status_i.is_bin_tail) begin
          cmd_o.start_emit = 1'b1;
          cmd_o.kind = dfpr_pkg::KIND_BIN;
          state_d = ST_EMIT;
        end
      end
      ST_TXT_DATA: begin
        if (acc) begin
          if (status_i.is_txt_stop) begin
            state_d = ST_TXT_WAIT;
          end else if (!status_i.txt_full) begin
            cmd_o.store_byte = 1'b1;
          end else begin
            cmd_o.set_ovf = 1'b1;
          end
        end
      end
      ST_TXT_WAIT: begin
        if (acc && status_i.is_txt_tail) begin
          cmd_o.start_emit = 1'b1;
          cmd_o.kind = dfpr_pkg::KIND_TXT;
          state_d = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (status_i.emit_done) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Hold state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

### rtl/dfpr_dp.sv
module dfpr_dp #(
  parameter int unsigned TextDepth = dfpr_pkg::TEXT_DEPTH_DEF,
  parameter int unsigned BinaryLen = dfpr_pkg::BIN_LEN_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic [7:0]                        in_byte_i,
  input  dfpr_pkg::cmd_t                    cmd_i,
  output dfpr_pkg::status_t                 status_o,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic [dfpr_pkg::BYTE_W-1:0]       out_byte_o,
  output logic [dfpr_pkg::INDEX_W-1:0]      out_index_o,
  output logic [dfpr_pkg::LEN_W-1:0]        out_len_o,
  output logic                              out_ovf_o,
  output logic                              out_kind_o,
  output logic                              out_last_o
);

  localparam int unsigned StoreSize = (TextDepth > BinaryLen) ? TextDepth : BinaryLen;
  localparam int unsigned AddrW     = $clog2(StoreSize);
  localparam int unsigned CntW      = $clog2(StoreSize + 1);

  logic [7:0]      mem [StoreSize];

  logic [CntW-1:0] wpos_q;
  logic            ovf_q;
  logic            emit_act_q;
  logic [CntW-1:0] total_q;
  logic [CntW-1:0] len_q;
  logic            zero_q;
  logic            kind_q;
  logic [CntW-1:0] rd_ptr_q;
  logic            fv_q;
  logic [CntW-1:0] fidx_q;
  logic [7:0]      rd_data_q;
  logic            ov_q;
  logic [7:0]      ob_q;
  logic [CntW-1:0] oidx_q;
  logic            olast_q;

  logic            issue;
  logic            fetch_move;

  // Decode the incoming word and store fill
  always_comb begin
    status_o.is_bin_head = (in_byte_i == dfpr_pkg::BIN_HEAD);
    status_o.is_bin_tail = (in_byte_i == dfpr_pkg::BIN_TAIL);
    status_o.is_txt_head = (in_byte_i == dfpr_pkg::TXT_HEAD);
    status_o.is_txt_stop = (in_byte_i == dfpr_pkg::TXT_STOP);
    status_o.is_txt_tail = (in_byte_i == dfpr_pkg::TXT_TAIL);
    status_o.bin_last    = ({1'b0, wpos_q} + (CntW + 1)'(1)) >= (CntW + 1)'(BinaryLen);
    status_o.txt_full    = wpos_q >= CntW'(TextDepth);
    status_o.emit_done   = ov_q && out_ready_i && olast_q;
  end

  // Read pipeline: one memory read in flight, one word in the output register
  assign fetch_move = fv_q && (!ov_q || out_ready_i);
  assign issue      = emit_act_q && (rd_ptr_q < total_q) && (!fv_q || fetch_move);

  // Write position, overflow flag and emit control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wpos_q     <= '0;
      ovf_q      <= 1'b0;
      emit_act_q <= 1'b0;
      total_q    <= '0;
      rd_ptr_q   <= '0;
      fv_q       <= 1'b0;
      ov_q       <= 1'b0;
    end else begin
      if (cmd_i.start_frame) begin
        wpos_q <= '0;
        ovf_q  <= 1'b0;
      end else if (cmd_i.store_byte) begin
        wpos_q <= wpos_q + CntW'(1);
      end
      if (cmd_i.set_ovf) begin
        ovf_q <= 1'b1;
      end

      if (cmd_i.start_emit) begin
        emit_act_q <= 1'b1;
        total_q    <= (wpos_q == '0) ? CntW'(1) : wpos_q;
        rd_ptr_q   <= '0;
      end else if (status_o.emit_done) begin
        emit_act_q <= 1'b0;
      end else if (issue) begin
        rd_ptr_q <= rd_ptr_q + CntW'(1);
      end

      if (issue) begin
        fv_q <= 1'b1;
      end else if (fetch_move) begin
        fv_q <= 1'b0;
      end

      if (fetch_move) begin
        ov_q <= 1'b1;
      end else if (out_ready_i) begin
        ov_q <= 1'b0;
      end
    end
  end

  // Payload store
  always_ff @(posedge clk_i) begin
    if (cmd_i.store_byte) begin
      mem[wpos_q[AddrW-1:0]] <= in_byte_i;
    end
    if (issue) begin
      rd_data_q <= mem[rd_ptr_q[AddrW-1:0]];
    end
  end

  // Frame attributes and output word
  always_ff @(posedge clk_i) begin
    if (cmd_i.start_emit) begin
      len_q  <= wpos_q;
      zero_q <= (wpos_q == '0);
      kind_q <= cmd_i.kind;
    end
    if (issue) begin
      fidx_q <= rd_ptr_q;
    end
    if (fetch_move) begin
      ob_q    <= zero_q ? 8'h00 : rd_data_q;
      oidx_q  <= fidx_q;
      olast_q <= ((fidx_q + CntW'(1)) == total_q);
    end
  end

  assign out_valid_o = ov_q;
  assign out_byte_o  = ob_q;
  assign out_index_o = dfpr_pkg::INDEX_W'(oidx_q);
  assign out_len_o   = dfpr_pkg::LEN_W'(len_q);
  assign out_ovf_o   = ovf_q;
  assign out_kind_o  = kind_q;
  assign out_last_o  = olast_q;

endmodule

### rtl/dual_format_packet_receiver.sv
// Dual-format packet receiver.
// Input stream: one received serial byte per word on s_axis_tdata. Binary frames
// open with 0xFF, carry BinaryLen payload bytes and close at 0xFE; text frames
// open with '@', carry payload up to '*' and close at '&'. Bytes outside a frame
// are dropped. Text beyond TextDepth bytes is dropped and flagged.
// Output stream: one word per stored payload byte once the frame closes, with
// its index, the frame length and overflow flag in tdata, the frame kind in
// tuser (0 binary, 1 text) and tlast on the final word. An empty text frame
// gives one zero word of length 0.
// Throughput: while parsing, one input word per cycle. After the closing byte
// the input is held off (s_axis_tready low) until the last output word is
// taken; with the sink always ready, a frame drains one word per cycle through
// the registered read of the payload store followed by the output register.
// A stalled sink holds the output word and the whole read pipeline.
// Reset clears the parser to waiting for a header and empties the output.
module dual_format_packet_receiver #(
  parameter int unsigned TextDepth = dfpr_pkg::TEXT_DEPTH_DEF,
  parameter int unsigned BinaryLen = dfpr_pkg::BIN_LEN_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  input  logic [7:0]                    s_axis_tdata,   // [7:0] rx_byte
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  // [7:0] payload_byte, [12:8] byte_index, [18:13] payload_length,
  // [19] overflowed, [23:20] zero
  output logic [dfpr_pkg::TDATA_W-1:0]  m_axis_tdata,
  output logic                          m_axis_tlast,   // last_byte
  output logic                          m_axis_tuser    // [0] frame_kind
);

  dfpr_pkg::cmd_t    cmd;
  dfpr_pkg::status_t status;

  logic [dfpr_pkg::BYTE_W-1:0]  out_byte;
  logic [dfpr_pkg::INDEX_W-1:0] out_index;
  logic [dfpr_pkg::LEN_W-1:0]   out_len;
  logic                         out_ovf;

  dfpr_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  dfpr_dp #(
    .TextDepth (TextDepth),
    .BinaryLen (BinaryLen)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_byte_i   (s_axis_tdata),
    .cmd_i       (cmd),
    .status_o    (status),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_byte_o  (out_byte),
    .out_index_o (out_index),
    .out_len_o   (out_len),
    .out_ovf_o   (out_ovf),
    .out_kind_o  (m_axis_tuser),
    .out_last_o  (m_axis_tlast)
  );

  // Pack output fields
  assign m_axis_tdata = {4'h0, out_ovf, out_len, out_index, out_byte};

  // Input is never taken while a frame is being sent
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(s_axis_tready && m_axis_tvalid))
    else $error("input accepted while output word pending");

  // The last word of a frame is followed by an idle output
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tready && m_axis_tlast) |=> !m_axis_tvalid)
    else $error("output word after end of frame");

  // A closing byte can only start a frame send when output is idle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.start_emit |-> !m_axis_tvalid)
    else $error("frame send started over a pending word");

endmodule
